// ===== rtl/matrix_matrix_multiply_core_assert.svh =====
// Assertion macros for the matrix multiply core.
`ifndef MATRIX_MATRIX_MULTIPLY_CORE_ASSERT_SVH
`define MATRIX_MATRIX_MULTIPLY_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Consequent must hold in the same cycle as the antecedent.
`define MMC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mmc: same-cycle check failed");
// Consequent must hold in the cycle after the antecedent.
`define MMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mmc: next-cycle check failed");
`else
`define MMC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define MMC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/mmc_pkg.sv =====
// Shared types and constants of the matrix multiply core.
`default_nettype none
package mmc_pkg;

	// Default largest matrix dimension.
	localparam int MAX_DIM_DEFAULT = 8;

	// Field widths fixed by the interface.
	localparam int OP_W      = 2;
	localparam int IDX_W     = 3;
	localparam int VALUE_W   = 16;
	localparam int RESULT_W  = 32;
	localparam int CFG_DIM_W = 4;
	localparam int CFG_IDX_W = 2;

	// Accumulator holds up to eight full products without wrapping.
	localparam int ACC_W = 35;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_WRITE_LEFT  = 2'd0;
	localparam logic [OP_W-1:0] OP_WRITE_RIGHT = 2'd1;
	localparam logic [OP_W-1:0] OP_COMPUTE     = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ROWS_OF_A  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_OF_B  = 2'd2;

	// Saturation limits of the result.
	localparam logic [RESULT_W-1:0] RESULT_MAX = {1'b0, {(RESULT_W-1){1'b1}}};
	localparam logic [RESULT_W-1:0] RESULT_MIN = {1'b1, {(RESULT_W-1){1'b0}}};

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             wr_left;
		logic             wr_right;
		logic             issue;
		logic             first;
		logic             last_k;
		logic             last_entry;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic [IDX_W-1:0] k;
	} mmc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic done;
		logic slot_free;
	} mmc_status_t;

endpackage
`default_nettype wire

// ===== rtl/matrix_matrix_multiply_core.sv =====
// Top level of the matrix multiply core.
`default_nettype none
`include "matrix_matrix_multiply_core_assert.svh"
// Computes C = A x B in fixed point. Each input word either writes one Q8.8
// entry of A (operation 0) or B (operation 1) into on-chip stores, or asks for
// the product (operation 2); operation 3 is dropped. Writes with an index at
// or beyond MAX_DIM are ignored. A product request streams out every entry of
// C in row-major order as Q16.16 values saturated to 32 bits, with last set on
// the final one. Sizes come from the rows_of_a, inner_size and cols_of_b
// registers (0 acts as 1, values above MAX_DIM act as MAX_DIM) and may only be
// changed while the core is idle. Store contents are undefined after reset, so
// every entry a product uses must be written first. A product holds off input
// until its last entry is in the output register. A single multiply-accumulate
// unit reads one entry of each store per cycle, but the first read of an entry
// waits until the output register is free; its read, multiply and accumulate
// stages drain between entries.
module matrix_matrix_multiply_core import mmc_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_write_en,
	input  wire logic [CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [CFG_DIM_W-1:0]      cfg_data,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [OP_W-1:0]           operation,
	input  wire logic [IDX_W-1:0]          row_index,
	input  wire logic [IDX_W-1:0]          col_index,
	input  wire logic signed [VALUE_W-1:0] entry_value,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [IDX_W-1:0]               out_row,
	output logic [IDX_W-1:0]               out_col,
	output logic signed [RESULT_W-1:0]     out_value,
	output logic                           last
);

	mmc_cmd_t    cmd;
	mmc_status_t status;

	// Sequencer.
	mmc_controller #(
		.MAX_DIM(MAX_DIM)
	) u_controller (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.operation   (operation),
		.in_ready    (in_ready),
		.status      (status),
		.cmd         (cmd)
	);

	// Stores and arithmetic.
	mmc_datapath #(
		.MAX_DIM(MAX_DIM)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.row_index  (row_index),
		.col_index  (col_index),
		.entry_value(entry_value),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.out_row    (out_row),
		.out_col    (out_col),
		.out_value  (out_value),
		.last       (last),
		.status     (status)
	);

	// A finished entry never lands on an output word that is still waiting.
	`MMC_ASSERT_NOW(a_done_slot_free, clk, arst_n, status.done, !out_valid || out_ready)
	// Multiply steps are only issued while the core is busy with a product.
	`MMC_ASSERT_NOW(a_issue_busy, clk, arst_n, cmd.issue, !in_ready)
	// An accepted product request makes the core busy in the next cycle.
	`MMC_ASSERT_NEXT(a_compute_busy, clk, arst_n, in_valid && in_ready && operation == OP_COMPUTE, !in_ready)

endmodule
`default_nettype wire

// ===== rtl/mmc_controller.sv =====
// Sequencer for store writes and the row, column and inner loops of a product.
`default_nettype none
module mmc_controller import mmc_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_write_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DIM_W-1:0] cfg_data,
	input  wire logic                 in_valid,
	input  wire logic [OP_W-1:0]      operation,
	output logic                      in_ready,
	input  wire mmc_status_t          status,
	output mmc_cmd_t                  cmd
);

	localparam int CNT_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_ISSUE = 2'd1;
	localparam logic [1:0] S_WAIT  = 2'd2;

	logic [1:0]           state_q;
	logic [CFG_DIM_W-1:0] rows_q;
	logic [CFG_DIM_W-1:0] inner_q;
	logic [CFG_DIM_W-1:0] cols_q;
	logic [CNT_W-1:0]     r_q;
	logic [CNT_W-1:0]     c_q;
	logic [CNT_W-1:0]     k_q;
	logic [CNT_W-1:0]     lim_r;
	logic [CNT_W-1:0]     lim_k;
	logic [CNT_W-1:0]     lim_c;
	logic                 issue;
	logic                 last_entry;

	// Turn a size register, clamped to 1..MAX_DIM, into the largest loop index.
	function automatic logic [CNT_W-1:0] dim_limit(input logic [CFG_DIM_W-1:0] v);
		logic [CNT_W-1:0] lim;
		if (v == '0) begin
			lim = '0;
		end else if (int'(v) > MAX_DIM) begin
			lim = CNT_W'(MAX_DIM - 1);
		end else begin
			lim = CNT_W'(v - CFG_DIM_W'(1));
		end
		return lim;
	endfunction

	assign lim_r = dim_limit(rows_q);
	assign lim_k = dim_limit(inner_q);
	assign lim_c = dim_limit(cols_q);

	assign in_ready   = (state_q == S_IDLE);
	assign last_entry = (r_q == lim_r) && (c_q == lim_c);

	// The first inner step of an entry waits for the output register to drain.
	assign issue = (state_q == S_ISSUE) && ((k_q != '0) || status.slot_free);

	// Command word to the datapath.
	always_comb begin
		cmd            = '0;
		cmd.wr_left    = in_ready && in_valid && (operation == OP_WRITE_LEFT);
		cmd.wr_right   = in_ready && in_valid && (operation == OP_WRITE_RIGHT);
		cmd.issue      = issue;
		cmd.first      = (k_q == '0);
		cmd.last_k     = (k_q == lim_k);
		cmd.last_entry = last_entry;
		cmd.row        = IDX_W'(r_q);
		cmd.col        = IDX_W'(c_q);
		cmd.k          = IDX_W'(k_q);
	end

	// Size registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= CFG_DIM_W'(MAX_DIM_DEFAULT);
			inner_q <= CFG_DIM_W'(MAX_DIM_DEFAULT);
			cols_q  <= CFG_DIM_W'(MAX_DIM_DEFAULT);
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_ROWS_OF_A:  rows_q  <= cfg_data;
				REG_INNER_SIZE: inner_q <= cfg_data;
				REG_COLS_OF_B:  cols_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Main state machine and loop counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			r_q     <= '0;
			c_q     <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && (operation == OP_COMPUTE)) begin
						r_q     <= '0;
						c_q     <= '0;
						k_q     <= '0;
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: begin
					if (issue) begin
						if (k_q == lim_k) begin
							k_q     <= '0;
							state_q <= S_WAIT;
						end else begin
							k_q <= k_q + CNT_W'(1);
						end
					end
				end
				S_WAIT: begin
					if (status.done) begin
						if (last_entry) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_ISSUE;
							if (c_q == lim_c) begin
								c_q <= '0;
								r_q <= r_q + CNT_W'(1);
							end else begin
								c_q <= c_q + CNT_W'(1);
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/mmc_datapath.sv =====
// Entry stores, multiply-accumulate pipeline and output register.
`default_nettype none
module mmc_datapath import mmc_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire mmc_cmd_t                   cmd,
	input  wire logic [IDX_W-1:0]           row_index,
	input  wire logic [IDX_W-1:0]           col_index,
	input  wire logic signed [VALUE_W-1:0]  entry_value,
	input  wire logic                       out_ready,
	output logic                            out_valid,
	output logic [IDX_W-1:0]                out_row,
	output logic [IDX_W-1:0]                out_col,
	output logic signed [RESULT_W-1:0]      out_value,
	output logic                            last,
	output mmc_status_t                     status
);

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [VALUE_W-1:0]         left_mem  [DEPTH];
	logic [VALUE_W-1:0]         right_mem [DEPTH];
	logic                       wr_in_range;
	logic [ADDR_W-1:0]          wr_addr;
	logic [ADDR_W-1:0]          rd_addr_left;
	logic [ADDR_W-1:0]          rd_addr_right;
	logic signed [VALUE_W-1:0]  a_s1;
	logic signed [VALUE_W-1:0]  b_s1;
	logic                       v_s1;
	logic                       first_s1;
	logic                       last_k_s1;
	logic                       last_entry_s1;
	logic [IDX_W-1:0]           row_s1;
	logic [IDX_W-1:0]           col_s1;
	logic signed [RESULT_W-1:0] prod_s2;
	logic                       v_s2;
	logic                       first_s2;
	logic                       last_k_s2;
	logic                       last_entry_s2;
	logic [IDX_W-1:0]           row_s2;
	logic [IDX_W-1:0]           col_s2;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [ACC_W-1:0]    acc_base;
	logic signed [ACC_W-1:0]    acc_sum;
	logic [RESULT_W-1:0]        sat_value;
	logic                       finish;

	// Store addresses: row-major with a row pitch of MAX_DIM.
	assign wr_in_range   = (int'(row_index) < MAX_DIM) && (int'(col_index) < MAX_DIM);
	assign wr_addr       = ADDR_W'(int'(row_index) * MAX_DIM + int'(col_index));
	assign rd_addr_left  = ADDR_W'(int'(cmd.row) * MAX_DIM + int'(cmd.k));
	assign rd_addr_right = ADDR_W'(int'(cmd.k) * MAX_DIM + int'(cmd.col));

	// Left store.
	always_ff @(posedge clk) begin
		if (cmd.wr_left && wr_in_range) begin
			left_mem[wr_addr] <= entry_value;
		end
		a_s1 <= left_mem[rd_addr_left];
	end

	// Right store.
	always_ff @(posedge clk) begin
		if (cmd.wr_right && wr_in_range) begin
			right_mem[wr_addr] <= entry_value;
		end
		b_s1 <= right_mem[rd_addr_right];
	end

	// Accumulate, and saturate the finished sum to 32 bits.
	assign acc_base = first_s2 ? '0 : acc_q;
	assign acc_sum  = acc_base + ACC_W'(prod_s2);
	always_comb begin
		if (acc_sum[ACC_W-1:RESULT_W-1] == {(ACC_W-RESULT_W+1){acc_sum[ACC_W-1]}}) begin
			sat_value = acc_sum[RESULT_W-1:0];
		end else if (acc_sum[ACC_W-1]) begin
			sat_value = RESULT_MIN;
		end else begin
			sat_value = RESULT_MAX;
		end
	end

	assign finish           = v_s2 && last_k_s2;
	assign status.done      = finish;
	assign status.slot_free = !out_valid || out_ready;

	// Pipeline and output valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			if (finish) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Pipeline payload: tags, product, accumulator and output word.
	always_ff @(posedge clk) begin
		first_s1      <= cmd.first;
		last_k_s1     <= cmd.last_k;
		last_entry_s1 <= cmd.last_entry;
		row_s1        <= cmd.row;
		col_s1        <= cmd.col;
		prod_s2       <= RESULT_W'(a_s1) * RESULT_W'(b_s1);
		first_s2      <= first_s1;
		last_k_s2     <= last_k_s1;
		last_entry_s2 <= last_entry_s1;
		row_s2        <= row_s1;
		col_s2        <= col_s1;
		if (v_s2) begin
			acc_q <= acc_sum;
		end
		if (finish) begin
			out_row   <= row_s2;
			out_col   <= col_s2;
			out_value <= sat_value;
			last      <= last_entry_s2;
		end
	end

endmodule
`default_nettype wire
